// ----- rtl/core/hacl_pkg.sv -----
// shared types, constants and helper functions for the hazard alarm panel
`timescale 1ns / 1ps
`default_nettype none

package hacl_pkg;

    localparam int KEY_W       = 4;
    localparam int DIGIT_W     = 3;
    localparam int MISS_W      = 4;
    localparam int ELAPSED_W   = 20;
    localparam int PHASE_W     = 16;
    localparam int CFG_INDEX_W = 3;

    localparam logic [MISS_W-1:0]    MISS_MAX    = '1;
    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

    // register map of the configuration port
    localparam logic [CFG_INDEX_W-1:0] CFG_SECRET_CODE  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_FAILURES = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_LOCKOUT      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_FAST_BLINK   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SLOW_BLINK   = 3'd4;

    localparam logic [MISS_W-1:0]    MAX_FAILURES_RESET = 4'd5;
    localparam logic [ELAPSED_W-1:0] LOCKOUT_RESET      = 20'd60000;
    localparam logic [PHASE_W-1:0]   FAST_BLINK_RESET   = 16'd200;
    localparam logic [PHASE_W-1:0]   SLOW_BLINK_RESET   = 16'd1000;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_ALARM  = 2'd1,
        MODE_EMERG  = 2'd2,
        MODE_LOCKED = 2'd3
    } mode_t;

    typedef struct packed {
        logic [MISS_W-1:0]    max_failures;
        logic [ELAPSED_W-1:0] lockout_ticks;
        logic [PHASE_W-1:0]   fast_blink_period;
        logic [PHASE_W-1:0]   slow_blink_period;
    } timing_cfg_t;

    typedef struct packed {
        logic             enable;
        logic [KEY_W-1:0] keys;
        logic             submit;
    } kp_ctrl_t;

    typedef struct packed {
        logic  alarm_lamp;
        logic  lock_lamp;
        mode_t panel_mode;
    } status_t;

    function automatic logic [PHASE_W-1:0] phase_step(
        input logic [PHASE_W-1:0] phase,
        input logic [PHASE_W-1:0] period
    );
        logic [PHASE_W:0] n;
        n = {1'b0, phase} + {{PHASE_W{1'b0}}, 1'b1};
        return (n >= {1'b0, period}) ? '0 : n[PHASE_W-1:0];
    endfunction

    function automatic logic lamp_on(
        input logic [PHASE_W-1:0] phase,
        input logic [PHASE_W-1:0] period
    );
        return phase < (period >> 1);
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/hacl_if.sv -----
// word channel interfaces: sensor tick words in, panel status words out
`timescale 1ns / 1ps
`default_nettype none

interface hacl_sensor_if;
    logic       valid;
    logic       ready;
    logic       gas_level;
    logic       temp_level;
    logic [3:0] key_mask;
    logic       submit_pulse;

    modport source (output valid, gas_level, temp_level, key_mask, submit_pulse,
                    input ready);
    modport sink   (input valid, gas_level, temp_level, key_mask, submit_pulse,
                    output ready);
endinterface

interface hacl_status_if;
    logic       valid;
    logic       ready;
    logic       alarm_lamp;
    logic       lock_lamp;
    logic [1:0] panel_mode;

    modport source (output valid, alarm_lamp, lock_lamp, panel_mode, input ready);
    modport sink   (input valid, alarm_lamp, lock_lamp, panel_mode, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/hacl_keypad.sv -----
// digit buffer, entry position and code compare
`timescale 1ns / 1ps
`default_nettype none

module hacl_keypad #(
    parameter int CODE_DIGITS = 4
) (
    input  wire logic                                       clk,
    input  wire logic                                       rst_n,
    input  wire hacl_pkg::kp_ctrl_t                         ctrl,
    input  wire logic [hacl_pkg::DIGIT_W*CODE_DIGITS-1:0]   secret_code,
    output logic                                            match
);
    import hacl_pkg::*;

    localparam int POS_W = $clog2(CODE_DIGITS + 1);
    localparam int IDX_W = $clog2(CODE_DIGITS);
    localparam logic [POS_W-1:0] POS_FULL = POS_W'(CODE_DIGITS);

    logic [DIGIT_W-1:0] digit_reg  [CODE_DIGITS];
    logic [DIGIT_W-1:0] digit_next [CODE_DIGITS];
    logic [POS_W-1:0]   pos_reg;
    logic [POS_W-1:0]   pos_next;
    logic [POS_W-1:0]   pos_walk;

    // keys go in ascending digit order while there is room
    always_comb
    begin
        digit_next = digit_reg;
        pos_walk   = pos_reg;
        for (int i = 0; i < KEY_W; i++)
        begin
            if (ctrl.keys[i] && (pos_walk < POS_FULL))
            begin
                digit_next[pos_walk[IDX_W-1:0]] = DIGIT_W'(i + 1);
                pos_walk = pos_walk + POS_W'(1);
            end
        end
        pos_next = ctrl.submit ? '0 : pos_walk;
    end

    always_comb
    begin
        match = 1'b1;
        for (int k = 0; k < CODE_DIGITS; k++)
        begin
            if (digit_next[k] != secret_code[DIGIT_W*k +: DIGIT_W])
                match = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            for (int k = 0; k < CODE_DIGITS; k++)
                digit_reg[k] <= '0;
        end
        else if (ctrl.enable)
        begin
            pos_reg   <= pos_next;
            digit_reg <= digit_next;
        end
    end

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_FULL)
        else $error("entry position past end of digit buffer");

endmodule

`default_nettype wire

// ----- rtl/core/hacl_ctrl.sv -----
// panel mode machine, miss counter, flash and lockout timers, lamps
`timescale 1ns / 1ps
`default_nettype none

module hacl_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  accept,
    input  wire logic                  gas_level,
    input  wire logic                  temp_level,
    input  wire logic [3:0]            key_mask,
    input  wire logic                  submit_pulse,
    input  wire hacl_pkg::timing_cfg_t cfg,
    input  wire logic                  match,
    output hacl_pkg::kp_ctrl_t         kp_ctrl,
    output hacl_pkg::status_t          status_next
);
    import hacl_pkg::*;

    mode_t                mode_reg, mode_next, mode_eff;
    logic                 alarm_lamp_reg, alarm_lamp_next;
    logic                 lock_lamp_reg, lock_lamp_next;
    logic [MISS_W-1:0]    miss_reg, miss_next, miss_inc;
    logic [PHASE_W-1:0]   flash_reg, flash_next, flash_cur;
    logic [ELAPSED_W-1:0] elapsed_reg, elapsed_next, elapsed_inc;
    logic [PHASE_W-1:0]   blink_reg, blink_next, blink_inc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_IDLE;
            alarm_lamp_reg <= 1'b0;
            lock_lamp_reg  <= 1'b0;
            miss_reg       <= '0;
            flash_reg      <= '0;
            elapsed_reg    <= '0;
            blink_reg      <= '0;
        end
        else if (accept)
        begin
            mode_reg       <= mode_next;
            alarm_lamp_reg <= alarm_lamp_next;
            lock_lamp_reg  <= lock_lamp_next;
            miss_reg       <= miss_next;
            flash_reg      <= flash_next;
            elapsed_reg    <= elapsed_next;
            blink_reg      <= blink_next;
        end
    end

    always_comb
    begin
        // sensors only matter in idle and alarm
        mode_eff  = mode_reg;
        flash_cur = flash_reg;
        if ((mode_reg == MODE_IDLE) || (mode_reg == MODE_ALARM))
        begin
            if (gas_level && temp_level)
            begin
                mode_eff  = MODE_EMERG;
                flash_cur = '0;
            end
            else if (gas_level || temp_level)
            begin
                mode_eff = MODE_ALARM;
            end
        end

        miss_inc    = (miss_reg < MISS_MAX) ? miss_reg + MISS_W'(1) : miss_reg;
        elapsed_inc = (elapsed_reg < ELAPSED_MAX) ? elapsed_reg + ELAPSED_W'(1)
                                                  : elapsed_reg;
        blink_inc   = phase_step(blink_reg, cfg.slow_blink_period);

        mode_next       = mode_eff;
        alarm_lamp_next = alarm_lamp_reg;
        lock_lamp_next  = lock_lamp_reg;
        miss_next       = miss_reg;
        flash_next      = flash_cur;
        elapsed_next    = elapsed_reg;
        blink_next      = blink_reg;

        kp_ctrl.enable = accept && (mode_eff == MODE_EMERG);
        kp_ctrl.keys   = key_mask;
        kp_ctrl.submit = submit_pulse;

        case (mode_eff)
            MODE_ALARM:
            begin
                alarm_lamp_next = 1'b1;
            end
            MODE_EMERG:
            begin
                alarm_lamp_next = lamp_on(flash_cur, cfg.fast_blink_period);
                flash_next      = phase_step(flash_cur, cfg.fast_blink_period);
                if (submit_pulse)
                begin
                    if (match)
                    begin
                        mode_next       = MODE_IDLE;
                        alarm_lamp_next = 1'b0;
                        lock_lamp_next  = 1'b0;
                        miss_next       = '0;
                        flash_next      = '0;
                        elapsed_next    = '0;
                        blink_next      = '0;
                    end
                    else if (miss_inc >= cfg.max_failures)
                    begin
                        // alarm lamp keeps its value through the lockout
                        mode_next    = MODE_LOCKED;
                        miss_next    = '0;
                        elapsed_next = '0;
                        blink_next   = '0;
                    end
                    else
                    begin
                        miss_next = miss_inc;
                    end
                end
            end
            MODE_LOCKED:
            begin
                if (elapsed_inc >= cfg.lockout_ticks)
                begin
                    mode_next       = MODE_IDLE;
                    alarm_lamp_next = 1'b0;
                    lock_lamp_next  = 1'b0;
                    miss_next       = '0;
                    flash_next      = '0;
                    elapsed_next    = '0;
                    blink_next      = '0;
                end
                else
                begin
                    elapsed_next   = elapsed_inc;
                    blink_next     = blink_inc;
                    lock_lamp_next = lamp_on(blink_inc, cfg.slow_blink_period);
                end
            end
            default:
            begin
            end
        endcase

        status_next.alarm_lamp = alarm_lamp_next;
        status_next.lock_lamp  = lock_lamp_next;
        status_next.panel_mode = mode_next;
    end

    a_idle_dark: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_IDLE) |-> (!alarm_lamp_reg && !lock_lamp_reg))
        else $error("lamp lit while panel idle");

    a_lock_lamp_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg != MODE_LOCKED) |-> (!lock_lamp_reg && (elapsed_reg == '0)
                                       && (blink_reg == '0)))
        else $error("lockout state active outside locked mode");

endmodule

`default_nettype wire

// ----- rtl/core/hazard_alarm_code_lockout_core.sv -----
// Hazard alarm panel with code lockout: one sensor word per millisecond tick.
//
// Channels: the sensor channel takes one word per tick (gas and temperature
// levels, a key mask with bit i meaning digit i+1, and a submit pulse). The
// status channel returns exactly one word per sensor word: alarm lamp, lock
// lamp and panel mode (idle, alarm, emergency, locked) as they stand after
// that tick.
// The status word is valid in the cycle after its sensor word is taken.
// The sensor channel takes one word per cycle while the receiver does not stall; the mode,
// timer and keypad update is a single combinational pass into the state registers.
// The status register is the only buffer, so while the receiver stalls a
// waiting status word holds and the sensor channel drops ready; ready
// returns in the cycle the waiting word is taken.
// Reset: mode idle, lamps off, counters and timers zero, digit buffer zero,
// registers back to their defaults (code 1,2,3,4, five misses, 60000-tick
// lockout, 200 and 1000 tick blink periods). Configuration writes are taken
// at any edge with cfg_wr_en high; write them only while the panel is idle.
`timescale 1ns / 1ps
`default_nettype none

module hazard_alarm_code_lockout_core #(
    parameter int CODE_DIGITS = 4
) (
    input  wire logic                                      clk,
    input  wire logic                                      rst_n,
    input  wire logic                                      cfg_wr_en,
    input  wire logic [hacl_pkg::CFG_INDEX_W-1:0]          cfg_index,
    input  wire logic [((3*CODE_DIGITS > 20) ? 3*CODE_DIGITS : 20)-1:0] cfg_wr_data,
    hacl_sensor_if.sink                                    sensor,
    hacl_status_if.source                                  status
);
    import hacl_pkg::*;

    localparam int SECRET_W = DIGIT_W * CODE_DIGITS;

    function automatic logic [SECRET_W-1:0] secret_default();
        logic [SECRET_W-1:0] s;
        s = '0;
        for (int k = 0; k < CODE_DIGITS; k++)
            s[DIGIT_W*k +: DIGIT_W] = DIGIT_W'(k + 1);
        return s;
    endfunction

    localparam logic [SECRET_W-1:0] SECRET_RESET = secret_default();

    logic [SECRET_W-1:0] secret_reg;
    timing_cfg_t         timing_reg;
    logic                accept;
    logic                match;
    kp_ctrl_t            kp_ctrl;
    status_t             status_next;
    status_t             res_reg;
    logic                res_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            secret_reg                   <= SECRET_RESET;
            timing_reg.max_failures      <= MAX_FAILURES_RESET;
            timing_reg.lockout_ticks     <= LOCKOUT_RESET;
            timing_reg.fast_blink_period <= FAST_BLINK_RESET;
            timing_reg.slow_blink_period <= SLOW_BLINK_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_SECRET_CODE:  secret_reg <= cfg_wr_data[SECRET_W-1:0];
                CFG_MAX_FAILURES: timing_reg.max_failures <= cfg_wr_data[MISS_W-1:0];
                CFG_LOCKOUT:      timing_reg.lockout_ticks <= cfg_wr_data[ELAPSED_W-1:0];
                CFG_FAST_BLINK:   timing_reg.fast_blink_period <= cfg_wr_data[PHASE_W-1:0];
                CFG_SLOW_BLINK:   timing_reg.slow_blink_period <= cfg_wr_data[PHASE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign sensor.ready = !res_valid_reg || status.ready;
    assign accept       = sensor.valid && sensor.ready;

    hacl_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .gas_level    (sensor.gas_level),
        .temp_level   (sensor.temp_level),
        .key_mask     (sensor.key_mask),
        .submit_pulse (sensor.submit_pulse),
        .cfg          (timing_reg),
        .match        (match),
        .kp_ctrl      (kp_ctrl),
        .status_next  (status_next)
    );

    hacl_keypad #(
        .CODE_DIGITS (CODE_DIGITS)
    ) u_keypad (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (kp_ctrl),
        .secret_code (secret_reg),
        .match       (match)
    );

    // status word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (accept)
            res_valid_reg <= 1'b1;
        else if (status.ready)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            res_reg <= status_next;
    end

    assign status.valid      = res_valid_reg;
    assign status.alarm_lamp = res_reg.alarm_lamp;
    assign status.lock_lamp  = res_reg.lock_lamp;
    assign status.panel_mode = res_reg.panel_mode;

    a_word_out: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> res_valid_reg)
        else $error("accepted sensor word produced no status word");

endmodule

`default_nettype wire
